[sv/pft2d_pkg.sv]
// Shared widths, register indexes and the quarter-wave sine table builder.
package pft2d_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_BITS  = 12;

    localparam int TRIG_W      = 16;
    localparam int SINE_W      = TRIG_W - 1;
    localparam int QUARTER     = 2 ** (ANGLE_BITS - 2);
    localparam int ROM_ADDR_W  = ANGLE_BITS - 1;
    localparam int FRAC_SHIFT  = 15;

    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = DIFF_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int RND_W       = SUM_W - FRAC_SHIFT;
    localparam int VAL_W       = RND_W + 1;

    localparam int TDATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = COORD_WIDTH;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING  = 2'd2;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd32767;

    localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TAYLOR_DIV [1:13] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
          64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702};

    typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER];

    // Builds round(32767 * sin(pi/2 * r / QUARTER)) for r = 0 .. QUARTER from a
    // Taylor series in Q62 fixed point. Evaluated once, at elaboration.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t    rom;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        logic [127:0] prod;
        for (int r = 0; r <= QUARTER; r++)
        begin
            x    = (PI_HALF_Q62 >> (ANGLE_BITS - 2)) * 64'(r);
            prod = x * x;
            x2   = prod[125:62];
            term = x;
            sum  = x;
            for (int k = 1; k <= 13; k++)
            begin
                prod = term * x2;
                term = prod[125:62] / TAYLOR_DIV[k];
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            v      = sum >> 20;
            v      = v * 64'd32767 + (64'd1 << 41);
            rom[r] = SINE_W'(v >> 42);
        end
        return rom;
    endfunction

endpackage

[sv/pose_frame_transform_2d.sv]
// Streaming 2D rigid transform of points between world and pose-local frames.
// A request passes through register stages A, B, C and D in order; D drives m_tvalid.
// Throughput: one point per cycle unless the output is held or a register write or heading latch
// blocks s_tready; the four register stages advance independently. A heading write stalls s_tready
// while the sine table is read and latched; a further heading write then restarts the table read.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the origin and the heading,
// and sets the latched cosine to 32767 and the sine to zero.
module pose_frame_transform_2d
    import pft2d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // point_x, point_y
    input  logic [0:0]             s_tuser,   // mode

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // result_x, result_y
    output logic [0:0]             m_tuser,   // clipped

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Sequencer that turns a heading write into latched cosine and sine values.
    typedef enum logic [1:0] {LAT_IDLE, LAT_READ, LAT_APPLY} lat_state_t;
    typedef enum logic [1:0] {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} quadrant_t;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    lat_state_t                     lat_state_reg;
    logic signed [COORD_WIDTH-1:0]  origin_x_reg;
    logic signed [COORD_WIDTH-1:0]  origin_y_reg;
    logic [ANGLE_BITS-1:0]          heading_reg;
    logic signed [TRIG_W-1:0]       cos_reg;
    logic signed [TRIG_W-1:0]       sin_reg;
    logic [SINE_W-1:0]              rom_s_reg;
    logic [SINE_W-1:0]              rom_c_reg;

    logic [ROM_ADDR_W-1:0]          addr_s;
    logic [ROM_ADDR_W-1:0]          addr_c;
    logic signed [TRIG_W-1:0]       s_val;
    logic signed [TRIG_W-1:0]       c_val;
    logic                           heading_wr;

    // The remainder within the quarter addresses the sine directly, and its
    // complement to a quarter turn addresses the cosine.
    assign addr_s = ROM_ADDR_W'(heading_reg[ANGLE_BITS-3:0]);
    assign addr_c = ROM_ADDR_W'(QUARTER) - addr_s;
    assign s_val  = $signed({1'b0, rom_s_reg});
    assign c_val  = $signed({1'b0, rom_c_reg});

    // Any heading write, in any sequencer state, starts a fresh table read.
    assign heading_wr = cfg_we && cfg_index == REG_HEADING;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_state_reg <= LAT_IDLE;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            heading_reg   <= '0;
            cos_reg       <= TRIG_ONE;
            sin_reg       <= '0;
            rom_s_reg     <= '0;
            rom_c_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: origin_x_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                    REG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                    REG_HEADING:  heading_reg  <= cfg_data[ANGLE_BITS-1:0];
                    default:      ;
                endcase
            end

            case (lat_state_reg)
                LAT_IDLE:
                begin
                    if (heading_wr)
                        lat_state_reg <= LAT_READ;
                end
                LAT_READ:
                begin
                    rom_s_reg     <= SINE_ROM[addr_s];
                    rom_c_reg     <= SINE_ROM[addr_c];
                    lat_state_reg <= heading_wr ? LAT_READ : LAT_APPLY;
                end
                LAT_APPLY:
                begin
                    // Fold the first-quadrant pair out to the full turn.
                    case (quadrant_t'(heading_reg[ANGLE_BITS-1 -: 2]))
                        QUAD_FIRST:
                        begin
                            sin_reg <= s_val;
                            cos_reg <= c_val;
                        end
                        QUAD_SECOND:
                        begin
                            sin_reg <= c_val;
                            cos_reg <= -s_val;
                        end
                        QUAD_THIRD:
                        begin
                            sin_reg <= -s_val;
                            cos_reg <= -c_val;
                        end
                        default:
                        begin
                            sin_reg <= -c_val;
                            cos_reg <= s_val;
                        end
                    endcase
                    lat_state_reg <= heading_wr ? LAT_READ : LAT_IDLE;
                end
                default: lat_state_reg <= LAT_IDLE;
            endcase
        end
    end

    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it is loading, so a stalled output never blocks the bubbles
    // behind it from closing up.
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic d_valid_reg;
    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic d_ready;
    logic s_fire;

    assign d_ready  = !d_valid_reg || m_tready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    // No request is taken during a register write or while the new heading is latched.
    assign s_tready = a_ready && lat_state_reg == LAT_IDLE && !cfg_we;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= s_fire;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    // Stage A: operands for the rotation. World to local first subtracts the
    // origin, one bit wider than a coordinate so the difference cannot wrap.
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [DIFF_W-1:0]      a_x_next;
    logic signed [DIFF_W-1:0]      a_y_next;
    logic signed [DIFF_W-1:0]      a_x_reg;
    logic signed [DIFF_W-1:0]      a_y_reg;
    logic                          a_mode_reg;

    assign px = $signed(s_tdata[COORD_WIDTH-1:0]);
    assign py = $signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

    always_comb
    begin
        if (s_tuser[0])
        begin
            a_x_next = DIFF_W'(px);
            a_y_next = DIFF_W'(py);
        end
        else
        begin
            a_x_next = DIFF_W'(px) - DIFF_W'(origin_x_reg);
            a_y_next = DIFF_W'(py) - DIFF_W'(origin_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_x_reg    <= a_x_next;
            a_y_reg    <= a_y_next;
            a_mode_reg <= s_tuser[0];
        end
    end

    // Stage B: the four products of the operands with the latched cosine and sine.
    logic signed [PROD_W-1:0] b_xc_reg;
    logic signed [PROD_W-1:0] b_xs_reg;
    logic signed [PROD_W-1:0] b_yc_reg;
    logic signed [PROD_W-1:0] b_ys_reg;
    logic                     b_mode_reg;

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_xc_reg   <= PROD_W'(a_x_reg * cos_reg);
            b_xs_reg   <= PROD_W'(a_x_reg * sin_reg);
            b_yc_reg   <= PROD_W'(a_y_reg * cos_reg);
            b_ys_reg   <= PROD_W'(a_y_reg * sin_reg);
            b_mode_reg <= a_mode_reg;
        end
    end

    // Stage C: combine the products with the signs of the chosen direction,
    // add one half and drop the fifteen fraction bits (ties go up).
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] half;
    logic signed [RND_W-1:0] c_x_reg;
    logic signed [RND_W-1:0] c_y_reg;
    logic                    c_mode_reg;

    assign half = SUM_W'(1) <<< (FRAC_SHIFT - 1);

    always_comb
    begin
        if (b_mode_reg)
        begin
            sum_x = SUM_W'(b_xc_reg) - SUM_W'(b_ys_reg) + half;
            sum_y = SUM_W'(b_xs_reg) + SUM_W'(b_yc_reg) + half;
        end
        else
        begin
            sum_x = SUM_W'(b_xc_reg) + SUM_W'(b_ys_reg) + half;
            sum_y = SUM_W'(b_yc_reg) - SUM_W'(b_xs_reg) + half;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && c_ready)
        begin
            c_x_reg    <= sum_x[SUM_W-1:FRAC_SHIFT];
            c_y_reg    <= sum_y[SUM_W-1:FRAC_SHIFT];
            c_mode_reg <= b_mode_reg;
        end
    end

    // Stage D: local to world adds the origin after rounding; then both
    // coordinates saturate to the coordinate width. This is the output register.
    logic signed [VAL_W-1:0]       val_x;
    logic signed [VAL_W-1:0]       val_y;
    logic [VAL_W-COORD_WIDTH:0]    top_x;
    logic [VAL_W-COORD_WIDTH:0]    top_y;
    logic                          ovf_x;
    logic                          ovf_y;
    logic signed [COORD_WIDTH-1:0] res_x_next;
    logic signed [COORD_WIDTH-1:0] res_y_next;
    logic signed [COORD_WIDTH-1:0] res_x_reg;
    logic signed [COORD_WIDTH-1:0] res_y_reg;
    logic                          clip_reg;

    always_comb
    begin
        if (c_mode_reg)
        begin
            val_x = VAL_W'(c_x_reg) + VAL_W'(origin_x_reg);
            val_y = VAL_W'(c_y_reg) + VAL_W'(origin_y_reg);
        end
        else
        begin
            val_x = VAL_W'(c_x_reg);
            val_y = VAL_W'(c_y_reg);
        end

        // A value fits when every bit from the coordinate's sign bit up agrees.
        top_x = val_x[VAL_W-1:COORD_WIDTH-1];
        top_y = val_y[VAL_W-1:COORD_WIDTH-1];
        ovf_x = !(&top_x || ~|top_x);
        ovf_y = !(&top_y || ~|top_y);

        if (ovf_x)
            res_x_next = val_x[VAL_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                        : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        else
            res_x_next = val_x[COORD_WIDTH-1:0];

        if (ovf_y)
            res_y_next = val_y[VAL_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                        : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        else
            res_y_next = val_y[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && d_ready)
        begin
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
            clip_reg  <= ovf_x || ovf_y;
        end
    end

    assign m_tvalid   = d_valid_reg;
    assign m_tdata    = TDATA_W'({res_y_reg, res_x_reg});
    assign m_tuser[0] = clip_reg;

    // A request is never taken while the heading latch is being updated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lat_state_reg != LAT_IDLE) |-> !s_tready)
        else $error("request accepted during heading latch update");

    // A heading write always starts the table read on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        heading_wr |=> (lat_state_reg == LAT_READ))
        else $error("heading write did not start the latch sequence");

    // A full stage whose successor cannot load keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> a_valid_reg)
        else $error("stage A item lost under stall");

    // A clipped result carries a saturation bound in at least one coordinate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && clip_reg) |->
        (res_x_reg == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
         res_x_reg == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
         res_y_reg == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
         res_y_reg == {1'b0, {(COORD_WIDTH-1){1'b1}}}))
        else $error("clip flag without a saturated coordinate");

endmodule

[tb/tb.sv]
// Self-checking testbench for the streaming 2D pose frame transform.
module tb;
    import pft2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes carried on s_tuser.
    localparam logic MODE_TO_LOCAL = 1'b0;
    localparam logic MODE_TO_WORLD = 1'b1;

    // The block decodes three register indexes; the fourth code must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int POINTS_PER_PHASE = 82;

    typedef struct {
        logic                   mode;
        logic [COORD_WIDTH-1:0] px;
        logic [COORD_WIDTH-1:0] py;
    } point_req_t;

    typedef struct {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic                   clip;
    } transformed_point_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;   // point_x, point_y
    logic [0:0]             s_tuser   = '0;   // mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;          // result_x, result_y
    logic [0:0]             m_tuser;          // clipped
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Point requests waiting to be driven, and the transforms we expect back.
    point_req_t         pending_points[$];
    transformed_point_t expected_points[$];

    // Our own copy of the pose: origin, heading and the latched trig values.
    longint             pose_x;
    longint             pose_y;
    logic [ANGLE_BITS-1:0] pose_heading;
    int                 pose_cos;
    int                 pose_sin;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;

    int                 error_count    = 0;
    int                 points_sent    = 0;
    int                 points_checked = 0;
    int                 clipped_seen   = 0;
    int                 reg_writes     = 0;
    int                 quiet_cycles   = 0;

    pose_frame_transform_2d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // One entry of the quarter-wave sine: round(32767 * sin(pi/2 * step / quarter)).
    // The sine is a 14-term Taylor series evaluated in unsigned Q62 fixed point, so the
    // values match the table that the block builds bit for bit.
    function automatic int quarter_wave(int unsigned step);
        logic [63:0]  ang;
        logic [63:0]  ang_sq;
        logic [63:0]  term;
        logic [63:0]  acc;
        logic [63:0]  scaled;
        logic [127:0] wide;
        ang    = (PI_HALF_Q62 >> (ANGLE_BITS - 2)) * 64'(step);
        wide   = {64'd0, ang} * {64'd0, ang};
        ang_sq = wide[125:62];
        term   = ang;
        acc    = ang;
        for (int k = 1; k <= 13; k++)
        begin
            wide = {64'd0, term} * {64'd0, ang_sq};
            term = wide[125:62] / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        scaled = (acc >> 20) * 64'd32767 + (64'd1 << 41);
        return int'(scaled >> 42);
    endfunction

    // Latch cosine and sine for the current heading by folding it into the first quadrant.
    function automatic void latch_heading_trig();
        int unsigned quarter;
        int unsigned quarter_step;
        int          s;
        int          c;
        quarter      = 1 << (ANGLE_BITS - 2);
        quarter_step = pose_heading[ANGLE_BITS-3:0];
        s            = quarter_wave(quarter_step);
        c            = quarter_wave(quarter - quarter_step);
        case (pose_heading[ANGLE_BITS-1:ANGLE_BITS-2])
            2'd0:
            begin
                pose_sin = s;
                pose_cos = c;
            end
            2'd1:
            begin
                pose_sin = c;
                pose_cos = -s;
            end
            2'd2:
            begin
                pose_sin = -s;
                pose_cos = -c;
            end
            default:
            begin
                pose_sin = -c;
                pose_cos = s;
            end
        endcase
    endfunction

    // Sum of two products, shifted right by 15 with a half added first, so ties go up.
    function automatic longint rotate_sum(longint a, int ca, longint b, int cb);
        longint total;
        total = a * ca + b * cb + 16384;
        return total >>> FRAC_SHIFT;
    endfunction

    function automatic longint clamp_coord(longint v, inout bit hit);
        if (v > COORD_MAX)
        begin
            hit = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            hit = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // Expected transform of one point under the current pose.
    function automatic transformed_point_t transform_point(logic mode,
                                                           logic [COORD_WIDTH-1:0] px_bits,
                                                           logic [COORD_WIDTH-1:0] py_bits);
        transformed_point_t res;
        longint             px;
        longint             py;
        longint             dx;
        longint             dy;
        longint             rx;
        longint             ry;
        bit                 hit;
        px  = longint'($signed(px_bits));
        py  = longint'($signed(py_bits));
        hit = 1'b0;
        if (mode == MODE_TO_LOCAL)
        begin
            // The difference is one bit wider than a coordinate and is never clamped.
            dx = px - pose_x;
            dy = py - pose_y;
            rx = rotate_sum(dx, pose_cos, dy, pose_sin);
            ry = rotate_sum(dx, -pose_sin, dy, pose_cos);
        end
        else
        begin
            // Rotation is rounded on its own before the origin is added.
            rx = pose_x + rotate_sum(px, pose_cos, py, -pose_sin);
            ry = pose_y + rotate_sum(px, pose_sin, py, pose_cos);
        end
        rx       = clamp_coord(rx, hit);
        ry       = clamp_coord(ry, hit);
        res.x    = rx[COORD_WIDTH-1:0];
        res.y    = ry[COORD_WIDTH-1:0];
        res.clip = hit;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [COORD_WIDTH-1:0] got,
                                   logic [COORD_WIDTH-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h (result %0d)",
                 $time, what, got, want, points_checked);
        error_count++;
    endtask

    // One register write through the plain write port; the pose copy follows it.
    // Writes are only issued while the block holds no work.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ORIGIN_X: pose_x = longint'($signed(value[COORD_WIDTH-1:0]));
            REG_ORIGIN_Y: pose_y = longint'($signed(value[COORD_WIDTH-1:0]));
            REG_HEADING:
            begin
                // Only the low angle bits of the write are kept.
                pose_heading = value[ANGLE_BITS-1:0];
                latch_heading_trig();
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    // Wait until every queued request was accepted and every result came back.
    task automatic drain_pipeline();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || s_tvalid || expected_points.size() != 0);
    endtask

    task automatic queue_point(logic mode, logic [COORD_WIDTH-1:0] px,
                               logic [COORD_WIDTH-1:0] py);
        point_req_t req;
        req.mode = mode;
        req.px   = px;
        req.py   = py;
        pending_points.push_back(req);
    endtask

    // The same directed set in both modes: zero, the corners of the coordinate range,
    // a pair of exact rounding ties at zero heading, and a one-LSB point.
    task automatic queue_directed_points();
        for (int m = 0; m < 2; m++)
        begin
            queue_point(m[0], 32'h0000_0000, 32'h0000_0000);
            queue_point(m[0], 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            queue_point(m[0], 32'h8000_0000, 32'h8000_0000);
            queue_point(m[0], 32'h7FFF_FFFF, 32'h8000_0000);
            queue_point(m[0], 32'h0000_4000, 32'hFFFF_C000);
            queue_point(m[0], 32'h0000_0001, 32'hFFFF_FFFF);
        end
    endtask

    // Coordinate mix: mostly full-range values, some small ones near the origin and
    // some edge values.
    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        logic [20:0] near;
        near = 21'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_4000;
                    default: return 32'hFFFF_C000;
                endcase
            end
            1, 2: return {{11{near[20]}}, near};
            default: return $urandom;
        endcase
    endfunction

    // A heading write: cardinal angles, step one and the top step now and then, else random.
    // The bits above the angle field are always random so that their masking is exercised.
    function automatic logic [CFG_DATA_W-1:0] pick_heading_word();
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 5))
                0: word[ANGLE_BITS-1:0] = 12'd0;
                1: word[ANGLE_BITS-1:0] = 12'd1024;
                2: word[ANGLE_BITS-1:0] = 12'd2048;
                3: word[ANGLE_BITS-1:0] = 12'd3072;
                4: word[ANGLE_BITS-1:0] = 12'd4095;
                default: word[ANGLE_BITS-1:0] = 12'd1;
            endcase
        end
        return word;
    endfunction

    // Stimulus sequencer. It resets the block, runs a directed part under the reset pose
    // and under an extreme pose, then random phases that each may change the pose and take one of
    // four idling patterns. Requests go into pending_points; the driver below sends them.
    initial
    begin
        pose_x       = 0;
        pose_y       = 0;
        pose_heading = '0;
        pose_cos     = 32767;
        pose_sin     = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed points under the pose that reset leaves behind.
        @(negedge clk);
        queue_directed_points();
        drain_pipeline();

        // Extreme origins, so that the world-to-local difference needs its extra bit.
        // The heading word has its upper bits set, and the unused index must change nothing.
        write_register(REG_ORIGIN_X, 32'h8000_0000);
        write_register(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_register(REG_HEADING, 32'hFFFF_F7FF);
        write_register(REG_UNUSED, $urandom);
        @(negedge clk);
        queue_directed_points();
        drain_pipeline();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase

            // The pipeline is empty here, so the pose may change.
            if ($urandom_range(0, 3) != 0)
                write_register(REG_ORIGIN_X, pick_coord());
            if ($urandom_range(0, 3) != 0)
                write_register(REG_ORIGIN_Y, pick_coord());
            if ($urandom_range(0, 3) != 0)
                write_register(REG_HEADING, pick_heading_word());
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNUSED, $urandom);

            @(negedge clk);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                queue_point(($urandom_range(0, 1) != 0) ? MODE_TO_WORLD : MODE_TO_LOCAL,
                            pick_coord(), pick_coord());
            drain_pipeline();
        end

        // Let any stray result show before the final report.
        repeat (8) @(posedge clk);
        while (expected_points.size() != 0)
        begin
            $display("%0t ns: expected result never arrived: x %h, y %h",
                     $time, expected_points[0].x, expected_points[0].y);
            void'(expected_points.pop_front());
            error_count++;
        end

        $display("Sent %0d points over %0d random phases plus the directed part, %0d checked.",
                 points_sent, RANDOM_PHASES, points_checked);
        $display("Register writes: %0d; saturated results: %0d; mismatches: %0d.",
                 reg_writes, clipped_seen, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Request driver. A request that was accepted at this edge is retired and its
    // expected transform is queued; then, if the sender is free, it decides whether to
    // present the next pending point or to idle. A presented request stays up until taken.
    always @(posedge clk)
    begin
        point_req_t next_req;
        bit         free;
        if (rst_n)
        begin
            free = 1'b0;
            if (s_tvalid && s_tready)
            begin
                expected_points.push_back(
                    transform_point(s_tuser[0], s_tdata[COORD_WIDTH-1:0],
                                    s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
                void'(pending_points.pop_front());
                points_sent++;
                free = 1'b1;
            end
            else if (!s_tvalid)
            begin
                free = 1'b1;
            end

            if (free)
            begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_points[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.py, next_req.px};
                    s_tuser  <= next_req.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result is checked field by field against the
    // oldest expected transform; the ready line then stalls at random for the next cycle.
    always @(posedge clk)
    begin
        transformed_point_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[COORD_WIDTH-1:0], '0);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (m_tdata[COORD_WIDTH-1:0] !== want.x)
                        report_mismatch("result_x", m_tdata[COORD_WIDTH-1:0], want.x);
                    if (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== want.y)
                        report_mismatch("result_y", m_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                                        want.y);
                    if (m_tuser[0] !== want.clip)
                        report_mismatch("clipped", COORD_WIDTH'(m_tuser[0]),
                                        COORD_WIDTH'(want.clip));
                end
                if (m_tuser[0] === 1'b1)
                    clipped_seen++;
                points_checked++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a long stretch with no handshake on either side means the block hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, expected_points.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
